>>> design/ldc_pkg.sv
package ldc_pkg;

  localparam int unsigned NumChips   = 2;
  localparam int unsigned ColBits    = 6;
  localparam int unsigned PageBits   = 3;
  localparam int unsigned AddrBits   = ColBits + PageBits;
  localparam int unsigned RamDepth   = 1 << AddrBits;
  localparam int unsigned DataBits   = 8;
  localparam int unsigned BusyBits   = 4;

  localparam int unsigned ChipA = 0;
  localparam int unsigned ChipB = 1;

  localparam logic [BusyBits-1:0] BusyEdgesReset = 4'd4;

  localparam logic [7:0] PortBothLo = 8'h50;
  localparam logic [7:0] PortBothHi = 8'h53;
  localparam logic [7:0] PortBLo    = 8'h54;
  localparam logic [7:0] PortBHi    = 8'h57;
  localparam logic [7:0] PortALo    = 8'h58;
  localparam logic [7:0] PortAHi    = 8'h5B;

  localparam logic [7:0] CmdDispOff = 8'h3E;
  localparam logic [7:0] CmdDispOn  = 8'h3F;
  localparam logic [7:0] CmdPageLo  = 8'hB8;
  localparam logic [7:0] CmdPageHi  = 8'hBF;
  localparam logic [7:0] CmdColLo   = 8'h40;
  localparam logic [7:0] CmdColHi   = 8'h7F;
  localparam logic [7:0] CmdLineLo  = 8'hC0;
  localparam logic [7:0] CmdLineHi  = 8'hFF;

  localparam logic [7:0] StatusOff  = 8'h20;
  localparam logic [7:0] StatusBusy = 8'h80;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OFF_CMD    = 2'd0,
    OFF_STATUS = 2'd1,
    OFF_DATA   = 2'd2,
    OFF_DREAD  = 2'd3
  } offset_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic clear;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

>>> design/ldc_ram.sv
module ldc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ldc_ctrl.sv
module ldc_ctrl import ldc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [1:0] offset_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   is_read;

  assign is_read = (func_e'(func_i) == FUNC_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    accept      = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        cmd_o.exec = accept;
        if (accept && is_read) begin
          out_valid_d = 1'b1;
          // pass through ST_LOAD to move the RAM byte into the output latch
          if (offset_e'(offset_i) == OFF_DREAD) begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> design/ldc_datapath.sv
module ldc_datapath import ldc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BusyBits-1:0] cfg_wdata_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          port_i,
  input  logic [7:0]          write_data_i,
  output logic [7:0]          read_data_o,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o
);

  logic [BusyBits-1:0] busy_edges_q;
  logic [AddrBits-1:0] clr_cnt_q;
  logic [7:0]          rdata_q, rdata_d;

  logic                disp_q    [NumChips];
  logic [PageBits-1:0] page_q    [NumChips];
  logic [ColBits-1:0]  col_q     [NumChips];
  logic [ColBits-1:0]  line_q    [NumChips];
  logic [7:0]          latch_q   [NumChips];
  logic [BusyBits-1:0] busy_q    [NumChips];
  logic                pend_q    [NumChips];
  logic [7:0]          ram_rdata [NumChips];
  logic [7:0]          status_b  [NumChips];

  logic          is_tick, is_read, is_write;
  offset_e       offset;
  logic          port_both, port_b, port_a;
  logic          rd_chip;
  logic [NumChips-1:0] sel_w;

  assign is_tick  = cmd_i.exec && (func_e'(func_i) == FUNC_TICK);
  assign is_read  = cmd_i.exec && (func_e'(func_i) == FUNC_READ);
  assign is_write = cmd_i.exec && (func_e'(func_i) == FUNC_WRITE);
  assign offset   = offset_e'(port_i[1:0]);

  assign port_both = port_i inside {[PortBothLo:PortBothHi]};
  assign port_b    = port_i inside {[PortBLo:PortBHi]};
  assign port_a    = port_i inside {[PortALo:PortAHi]};
  assign rd_chip   = port_b;
  assign sel_w[ChipA] = port_both || port_a;
  assign sel_w[ChipB] = port_both || port_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_edges_q <= BusyEdgesReset;
      clr_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        busy_edges_q <= cfg_wdata_i;
      end
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign status_o.clear_last = (clr_cnt_q == {AddrBits{1'b1}});

  for (genvar c = 0; c < NumChips; c++) begin : g_chip
    logic                cmd_w, data_w, dread;
    logic                ram_we;
    logic [AddrBits-1:0] ram_addr;
    logic [7:0]          ram_wdata;

    assign cmd_w  = is_write && sel_w[c] && (offset == OFF_CMD);
    assign data_w = is_write && sel_w[c] && (offset == OFF_DATA);
    assign dread  = is_read && (rd_chip == 1'(c)) && (offset == OFF_DREAD);

    assign status_b[c] = (disp_q[c] ? 8'h00 : StatusOff)
                       | ((busy_q[c] != '0) ? StatusBusy : 8'h00);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        disp_q[c]  <= 1'b0;
        page_q[c]  <= '0;
        col_q[c]   <= '0;
        line_q[c]  <= '0;
        latch_q[c] <= '0;
        busy_q[c]  <= '0;
        pend_q[c]  <= 1'b0;
      end else begin
        pend_q[c] <= dread;
        if (cmd_i.load && pend_q[c]) begin
          latch_q[c] <= ram_rdata[c];
        end
        if (cmd_w || data_w) begin
          busy_q[c] <= busy_edges_q;
        end else if (is_tick && (busy_q[c] != '0)) begin
          busy_q[c] <= busy_q[c] - 1'b1;
        end
        if (data_w || dread) begin
          col_q[c] <= col_q[c] + 1'b1;
        end
        if (cmd_w) begin
          if (write_data_i == CmdDispOff) begin
            disp_q[c] <= 1'b0;
          end else if (write_data_i == CmdDispOn) begin
            disp_q[c] <= 1'b1;
          end else if (write_data_i inside {[CmdPageLo:CmdPageHi]}) begin
            page_q[c] <= write_data_i[PageBits-1:0];
          end else if (write_data_i inside {[CmdColLo:CmdColHi]}) begin
            col_q[c] <= write_data_i[ColBits-1:0];
          end else if (write_data_i inside {[CmdLineLo:CmdLineHi]}) begin
            line_q[c] <= write_data_i[ColBits-1:0];
          end
        end
      end
    end

    assign ram_we    = cmd_i.clear || data_w;
    assign ram_addr  = cmd_i.clear ? clr_cnt_q : {col_q[c], page_q[c]};
    assign ram_wdata = cmd_i.clear ? 8'h00 : write_data_i;

    ldc_ram #(
      .Width(DataBits),
      .Depth(RamDepth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .addr_i (ram_addr),
      .wdata_i(ram_wdata),
      .rdata_o(ram_rdata[c])
    );
  end

  always_comb begin
    rdata_d = rdata_q;
    if (is_read) begin
      if (offset == OFF_DREAD) begin
        rdata_d = rd_chip ? latch_q[ChipB] : latch_q[ChipA];
      end else begin
        rdata_d = rd_chip ? status_b[ChipB] : status_b[ChipA];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
  end

  assign read_data_o = rdata_q;

endmodule

>>> design/dual_lcd_column_controller.sv
// A port read presents its byte in the cycle after the request is accepted.
// Ticks, writes and status reads are taken back to back unless the output stalls;
// a data read adds ST_LOAD, as the column byte passes the registered RAM port.
// Reset: asynchronous, active low; control registers clear at once, then both
// display RAMs are zeroed over all 512 addresses with no requests taken.
module dual_lcd_column_controller import ldc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BusyBits-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [7:0]          port_i,
  input  logic [7:0]          write_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          read_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ldc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .offset_i   (port_i[1:0]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  ldc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (func_i),
    .port_i      (port_i),
    .write_data_i(write_data_i),
    .read_data_o (read_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
